[rtl/bitmap_font_text_renderer_assert.svh]
// Assertion macros for the bitmap font text renderer.
// Needs clk and rst_n in the scope that uses them.
`ifndef BITMAP_FONT_TEXT_RENDERER_ASSERT_SVH
`define BITMAP_FONT_TEXT_RENDERER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BFTR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bftr assertion failed");

// Next-cycle implication, checked out of reset.
`define BFTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bftr assertion failed");

`endif

[rtl/bftr_pkg.sv]
// Shared types and constants for the bitmap font text renderer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bftr_pkg;

    localparam int GLYPHS_DEF       = 512;
    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int GLYPH_WIDTH_DEF  = 8;
    localparam int COORD_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH      = 4;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] LEFT_BIT     = 8'h80;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X   = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y   = 3'd1;
    localparam logic [2:0] CFG_FOREGROUND = 3'd2;
    localparam logic [2:0] CFG_BACKGROUND = 3'd3;
    localparam logic [2:0] CFG_OPAQUE     = 3'd4;
    localparam logic [2:0] CFG_GLYPH_TOT  = 3'd5;

    // queued command kinds
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_DRAW,
        OP_ERROR
    } op_t;

    typedef enum logic {
        BK_IDLE,
        BK_ROWS
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // columns that lie inside the glyph cell, leftmost at bit 7
    function automatic logic [7:0] column_mask(input int width);
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (i < width)
            begin
                m = m | (LEFT_BIT >> i);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/bitmap_font_text_renderer.sv]
// Bitmap font text renderer (character generator).
//
// Input channel (in_valid/in_ready): mode 0 words load one glyph row byte,
// mode 1 words draw one character. Output channel (out_valid/out_ready)
// carries one pixel row word per glyph row, or one error word for a code
// outside the font. Configuration is a write port (cfg_wen, cfg_addr,
// cfg_wdata); the user must write it only while the block is idle, as the
// block itself does not enforce this. The first row of a character passes
// through the command queue, the read stage and the output register. A
// character holds the back end for one glyph store read per row through
// the single read port; newlines and halted words are not queued.
// A 4-entry command queue lets input words flow on while rows are emitted.
// Reset clears the cursor, the halt flag and the registers to their
// defaults; the glyph store is not cleared and must be loaded before use.
// When the receiver stalls the output word holds, the read stage and queue
// fill, and then in_ready drops.
// Depends on bftr_pkg, bftr_front, bftr_queue, bftr_back.
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_font_text_renderer_assert.svh"

module bitmap_font_text_renderer #(
    parameter int GLYPHS       = bftr_pkg::GLYPHS_DEF,
    parameter int GLYPH_HEIGHT = bftr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_WIDTH  = bftr_pkg::GLYPH_WIDTH_DEF,
    parameter int COORD_BITS   = bftr_pkg::COORD_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wen,
    input  wire logic [2:0]         cfg_addr,
    input  wire logic [31:0]        cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic               first,
    input  wire logic [7:0]         character,
    input  wire logic [8:0]         glyph_index,
    input  wire logic [3:0]         glyph_row,
    input  wire logic [7:0]         row_bits,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    status,
    output logic signed [15:0]      pixel_x,
    output logic signed [15:0]      pixel_y,
    output logic [7:0]              set_bits,
    output logic [7:0]              write_mask,
    output logic [31:0]             fore_value,
    output logic [31:0]             back_value,
    output logic                    last
);

    localparam int GI_BITS = $clog2(GLYPHS);
    localparam int RB      = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int EW      = 2 + GI_BITS + RB + 8 + 2 * COORD_BITS;

    logic [15:0] origin_x_reg, origin_y_reg;
    logic [31:0] foreground_reg, background_reg;
    logic        opaque_reg;
    logic [9:0]  glyph_total_reg;

    logic              q_push, q_pop;
    logic [EW-1:0]     q_in, q_out;
    bftr_pkg::qstat_t  qstat;
    logic [15:0]       px_u, py_u;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= '0;
            origin_y_reg    <= '0;
            foreground_reg  <= 32'hFFFF_FFFF;
            background_reg  <= '0;
            opaque_reg      <= 1'b0;
            glyph_total_reg <= 10'd256;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                bftr_pkg::CFG_ORIGIN_X:   origin_x_reg    <= cfg_wdata[15:0];
                bftr_pkg::CFG_ORIGIN_Y:   origin_y_reg    <= cfg_wdata[15:0];
                bftr_pkg::CFG_FOREGROUND: foreground_reg  <= cfg_wdata;
                bftr_pkg::CFG_BACKGROUND: background_reg  <= cfg_wdata;
                bftr_pkg::CFG_OPAQUE:     opaque_reg      <= cfg_wdata[0];
                bftr_pkg::CFG_GLYPH_TOT:  glyph_total_reg <= cfg_wdata[9:0];
                default:                  opaque_reg      <= opaque_reg;
            endcase
        end
    end

    bftr_front #(
        .GLYPHS       (GLYPHS),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .first        (first),
        .character    (character),
        .glyph_index  (glyph_index),
        .glyph_row    (glyph_row),
        .row_bits     (row_bits),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .glyph_total  (glyph_total_reg),
        .qstat        (qstat),
        .push         (q_push),
        .push_data    (q_in)
    );

    bftr_queue #(
        .WIDTH (EW),
        .DEPTH (bftr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .qstat     (qstat)
    );

    bftr_back #(
        .GLYPHS       (GLYPHS),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .qstat            (qstat),
        .pop              (q_pop),
        .pop_data         (q_out),
        .opaque_mode      (opaque_reg),
        .foreground_color (foreground_reg),
        .background_color (background_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .status           (status),
        .pixel_x          (px_u),
        .pixel_y          (py_u),
        .set_bits         (set_bits),
        .write_mask       (write_mask),
        .fore_value       (fore_value),
        .back_value       (back_value),
        .last             (last)
    );

    assign pixel_x = $signed(px_u);
    assign pixel_y = $signed(py_u);

    `BFTR_ASSERT_NOW(a_no_push_full, q_push, !qstat.full)
    `BFTR_ASSERT_NOW(a_no_pop_empty, q_pop, !qstat.empty)
    `BFTR_ASSERT_NOW(a_error_word, out_valid && status,
        set_bits == 8'h00 && write_mask == 8'h00 && last)
    `BFTR_ASSERT_NOW(a_mask_covers, out_valid, (set_bits & ~write_mask) == 8'h00)
    `BFTR_ASSERT_NEXT(a_push_lands, q_push && !q_pop, !qstat.empty)

endmodule

`default_nettype wire

[rtl/bftr_queue.sv]
// Small register queue between the front and back ends.
// Depends on bftr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bftr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bftr_pkg::QUEUE_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   push_data,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        pop_data,
    output bftr_pkg::qstat_t        qstat
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_comb
    begin
        head_next  = pop ? bump(head_reg) : head_reg;
        tail_next  = push ? bump(tail_reg) : tail_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    assign pop_data    = slot_reg[head_reg];
    assign qstat.full  = (count_reg == CW'(DEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

`default_nettype wire

[rtl/bftr_front.sv]
// Front end: accepts input words, keeps the cursor and halt flag,
// and queues load, draw and error commands. Depends on bftr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bftr_front #(
    parameter int GLYPHS       = bftr_pkg::GLYPHS_DEF,
    parameter int GLYPH_HEIGHT = bftr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_WIDTH  = bftr_pkg::GLYPH_WIDTH_DEF,
    parameter int COORD_BITS   = bftr_pkg::COORD_BITS_DEF,
    localparam int GI_BITS     = $clog2(GLYPHS),
    localparam int RB          = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1,
    localparam int EW          = 2 + GI_BITS + RB + 8 + 2 * COORD_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               mode,
    input  wire logic               first,
    input  wire logic [7:0]         character,
    input  wire logic [8:0]         glyph_index,
    input  wire logic [3:0]         glyph_row,
    input  wire logic [7:0]         row_bits,
    input  wire logic [15:0]        origin_x,
    input  wire logic [15:0]        origin_y,
    input  wire logic [9:0]         glyph_total,
    input  wire bftr_pkg::qstat_t   qstat,
    output logic                    push,
    output logic [EW-1:0]           push_data
);

    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic                  halted_reg, halted_next;

    logic [COORD_BITS-1:0] org_x_w, org_y_w, eff_x, eff_y;
    logic                  eff_halted, accept, ld_ok, code_ok;
    logic [31:0]           sx32, sy32;
    logic [12:0]           gi_ext, code_ext;
    logic [5:0]            row_ext;
    bftr_pkg::op_t         op;
    logic [GI_BITS-1:0]    gi;
    logic [RB-1:0]         row;

    // origin is sign-extended into the coordinate width
    assign sx32    = 32'($signed(origin_x));
    assign sy32    = 32'($signed(origin_y));
    assign org_x_w = sx32[COORD_BITS-1:0];
    assign org_y_w = sy32[COORD_BITS-1:0];

    assign gi_ext   = {4'b0, glyph_index};
    assign code_ext = {5'b0, character};
    assign row_ext  = {2'b0, glyph_row};
    assign ld_ok    = (gi_ext < 13'(GLYPHS)) && (row_ext < 6'(GLYPH_HEIGHT));
    assign code_ok  = ({2'b0, character} < glyph_total) && (code_ext < 13'(GLYPHS));

    assign in_ready   = !qstat.full;
    assign accept     = in_valid && in_ready;
    assign eff_x      = first ? org_x_w : cursor_x_reg;
    assign eff_y      = first ? org_y_w : cursor_y_reg;
    assign eff_halted = first ? 1'b0 : halted_reg;

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        halted_next   = halted_reg;
        push          = 1'b0;
        op            = bftr_pkg::OP_LOAD;
        gi            = gi_ext[GI_BITS-1:0];
        row           = row_ext[RB-1:0];
        if (accept)
        begin
            if (!mode)
            begin
                push = ld_ok;
            end
            else
            begin
                cursor_x_next = eff_x;
                cursor_y_next = eff_y;
                halted_next   = eff_halted;
                gi            = code_ext[GI_BITS-1:0];
                if (!eff_halted)
                begin
                    if (character == bftr_pkg::NEWLINE_CODE)
                    begin
                        cursor_x_next = org_x_w;
                        cursor_y_next = eff_y + COORD_BITS'(GLYPH_HEIGHT);
                    end
                    else if (!code_ok)
                    begin
                        halted_next = 1'b1;
                        push        = 1'b1;
                        op          = bftr_pkg::OP_ERROR;
                    end
                    else
                    begin
                        push          = 1'b1;
                        op            = bftr_pkg::OP_DRAW;
                        cursor_x_next = eff_x + COORD_BITS'(GLYPH_WIDTH);
                    end
                end
            end
        end
    end

    assign push_data = {op, gi, row, row_bits, eff_x, eff_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

`default_nettype wire

[rtl/bftr_back.sv]
// Back end: glyph store, row sequencer, read stage and output register.
// Depends on bftr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bftr_back #(
    parameter int GLYPHS       = bftr_pkg::GLYPHS_DEF,
    parameter int GLYPH_HEIGHT = bftr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_WIDTH  = bftr_pkg::GLYPH_WIDTH_DEF,
    parameter int COORD_BITS   = bftr_pkg::COORD_BITS_DEF,
    localparam int GI_BITS     = $clog2(GLYPHS),
    localparam int RB          = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1,
    localparam int EW          = 2 + GI_BITS + RB + 8 + 2 * COORD_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bftr_pkg::qstat_t   qstat,
    output logic                    pop,
    input  wire logic [EW-1:0]      pop_data,
    input  wire logic               opaque_mode,
    input  wire logic [31:0]        foreground_color,
    input  wire logic [31:0]        background_color,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    status,
    output logic [15:0]             pixel_x,
    output logic [15:0]             pixel_y,
    output logic [7:0]              set_bits,
    output logic [7:0]              write_mask,
    output logic [31:0]             fore_value,
    output logic [31:0]             back_value,
    output logic                    last
);

    localparam int STORE_DEPTH    = GLYPHS << RB;
    localparam int AW             = GI_BITS + RB;
    localparam logic [RB-1:0] LAST_ROW = RB'(GLYPH_HEIGHT - 1);
    localparam logic [7:0] COL_MASK    = bftr_pkg::column_mask(GLYPH_WIDTH);

    logic [7:0] store_mem [STORE_DEPTH];

    bftr_pkg::back_state_t state_reg, state_next;
    bftr_pkg::op_t         e_op;
    logic [GI_BITS-1:0]    e_gi;
    logic [RB-1:0]         e_row;
    logic [7:0]            e_data;
    logic [COORD_BITS-1:0] e_x, e_y;

    logic [GI_BITS-1:0]    gi_reg, gi_next;
    logic [RB-1:0]         row_reg, row_next;
    logic [COORD_BITS-1:0] x_reg, x_next, y_reg, y_next;

    logic                  wr_en, rd_en, s1_load, s1_err, s1_last;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [COORD_BITS-1:0] s1_x, s1_y;

    logic                  s1_valid_reg, s1_err_reg, s1_last_reg;
    logic [COORD_BITS-1:0] s1_x_reg, s1_y_reg;
    logic [7:0]            rd_data_reg;

    logic                  out_valid_reg, status_reg, last_reg;
    logic [15:0]           pixel_x_reg, pixel_y_reg;
    logic [7:0]            set_bits_reg, write_mask_reg;
    logic [31:0]           fore_value_reg, back_value_reg;
    logic [7:0]            set_next;
    logic [31:0]           px32, py32;

    logic out_free, s1_free;

    assign {e_op, e_gi, e_row, e_data, e_x, e_y} = pop_data;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bftr_pkg::BK_IDLE:
            begin
                if (s1_free && !qstat.empty && e_op == bftr_pkg::OP_DRAW
                    && GLYPH_HEIGHT > 1)
                begin
                    state_next = bftr_pkg::BK_ROWS;
                end
            end
            bftr_pkg::BK_ROWS:
            begin
                if (s1_free && row_reg == LAST_ROW)
                begin
                    state_next = bftr_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = bftr_pkg::BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = {e_gi, e_row};
        rd_en    = 1'b0;
        rd_addr  = {gi_reg, row_reg};
        s1_load  = 1'b0;
        s1_err   = 1'b0;
        s1_last  = 1'b0;
        s1_x     = x_reg;
        s1_y     = y_reg + COORD_BITS'(row_reg);
        gi_next  = gi_reg;
        row_next = row_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        case (state_reg)
            bftr_pkg::BK_IDLE:
            begin
                if (s1_free && !qstat.empty)
                begin
                    pop = 1'b1;
                    case (e_op)
                        bftr_pkg::OP_LOAD:
                        begin
                            wr_en = 1'b1;
                        end
                        bftr_pkg::OP_ERROR:
                        begin
                            s1_load = 1'b1;
                            s1_err  = 1'b1;
                            s1_last = 1'b1;
                            s1_x    = e_x;
                            s1_y    = e_y;
                        end
                        bftr_pkg::OP_DRAW:
                        begin
                            // top row goes out straight away
                            rd_en    = 1'b1;
                            rd_addr  = {e_gi, RB'(0)};
                            s1_load  = 1'b1;
                            s1_last  = (GLYPH_HEIGHT == 1);
                            s1_x     = e_x;
                            s1_y     = e_y;
                            gi_next  = e_gi;
                            row_next = RB'(1);
                            x_next   = e_x;
                            y_next   = e_y;
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            bftr_pkg::BK_ROWS:
            begin
                if (s1_free)
                begin
                    rd_en    = 1'b1;
                    s1_load  = 1'b1;
                    s1_last  = (row_reg == LAST_ROW);
                    row_next = row_reg + RB'(1);
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= e_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign set_next = s1_err_reg ? 8'h00 : (rd_data_reg & COL_MASK);
    assign px32     = 32'(s1_x_reg);
    assign py32     = 32'(s1_y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bftr_pkg::BK_IDLE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s1_load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        gi_reg  <= gi_next;
        row_reg <= row_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (s1_load)
        begin
            s1_err_reg  <= s1_err;
            s1_last_reg <= s1_last;
            s1_x_reg    <= s1_x;
            s1_y_reg    <= s1_y;
        end
        if (out_free && s1_valid_reg)
        begin
            status_reg     <= s1_err_reg;
            pixel_x_reg    <= px32[15:0];
            pixel_y_reg    <= py32[15:0];
            set_bits_reg   <= set_next;
            write_mask_reg <= s1_err_reg ? 8'h00 : (opaque_mode ? COL_MASK : set_next);
            fore_value_reg <= s1_err_reg ? 32'h0 : foreground_color;
            back_value_reg <= (s1_err_reg || !opaque_mode) ? 32'h0 : background_color;
            last_reg       <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign pixel_x    = pixel_x_reg;
    assign pixel_y    = pixel_y_reg;
    assign set_bits   = set_bits_reg;
    assign write_mask = write_mask_reg;
    assign fore_value = fore_value_reg;
    assign back_value = back_value_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire
